/* hw/rtl/rcppm_pkg.sv */
`default_nettype none
package rcppm_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_FRAME_PERIOD = 3'd0;
	localparam logic [2:0] REG_SEP_LOW      = 3'd1;
	localparam logic [2:0] REG_CHAN0        = 3'd2;

	localparam int REG_CHANNELS = 6;

	// Timing constants in ticks
	localparam logic [15:0] SEP_RESET    = 16'h2FB5;
	localparam logic [15:0] BASE_TICKS   = 16'h478F;
	localparam logic [15:0] SPAN_TICKS   = 16'h7763;
	localparam logic [23:0] PERIOD_RESET = {8'hA, 16'h4000};

	// Reset channel positions (10-bit register values)
	localparam logic [9:0] CHAN_RESET [REG_CHANNELS] = '{
		10'd0, 10'd128, 10'd256, 10'd512, 10'd768, 10'd1023
	};

	// Output item bit positions in tdata
	localparam int OUT_LEVEL_BIT = 0;
	localparam int OUT_SLOT_LSB  = 1;
	localparam int OUT_FSTART_BIT = 4;
	localparam int OUT_OVR_BIT   = 5;

	localparam logic [2:0] SLOT_IDLE = 3'd7;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SEP  = 2'd1,
		PH_CHAN = 2'd2
	} phase_t;

endpackage
`default_nettype wire

/* hw/rtl/rc_ppm_frame_generator.sv */
// A result item is valid in the cycle after its tick request is accepted.
// Throughput: one tick request per cycle; s_axis_tready stays high while the
//   result register is empty or being drained in the same cycle.
// Channel interval widths are computed when a register is written, so the
//   per-tick path is a counter decrement, a 24-bit compare and a table select.
// Reset (arst_n low, asynchronous): line idle high, counters zero, registers
//   at their reset values, no result pending.
`default_nettype none
module rc_ppm_frame_generator
	import rcppm_pkg::*;
#(
	parameter int CHAN_COUNT = 6,
	parameter int VALUE_BITS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// tick request
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [0] tick, [7:1] zero
	// result
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [0] ppm_level, [3:1] active_slot,
	                                         // [4] frame_start, [5] overrun, [7:6] zero
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	localparam int KEEP_BITS = (VALUE_BITS < 10) ? VALUE_BITS : 10;
	localparam logic [9:0] VALUE_MASK = 10'((32'd1 << KEEP_BITS) - 32'd1);

	// Interval reload for a channel position: base + (v * span) >> VALUE_BITS, minus one
	function automatic logic [15:0] chan_load(input logic [9:0] v);
		logic [31:0] prod;
		logic [31:0] dur;
		prod = {22'd0, v & VALUE_MASK} * {16'd0, SPAN_TICKS};
		dur  = {16'd0, BASE_TICKS} + (prod >> VALUE_BITS);
		return dur[15:0] - 16'd1;
	endfunction

	// Configuration registers
	logic [23:0] period_q;
	logic [15:0] sep_load_q;
	logic [15:0] chan_load_q [REG_CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= PERIOD_RESET;
			sep_load_q <= SEP_RESET - 16'd1;
			for (int i = 0; i < REG_CHANNELS; i++) begin
				chan_load_q[i] <= chan_load(CHAN_RESET[i]);
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_PERIOD: period_q <= cfg_data;
				REG_SEP_LOW: begin
					sep_load_q <= (cfg_data[15:0] == 16'd0) ? 16'd0 : cfg_data[15:0] - 16'd1;
				end
				default: begin
					chan_load_q[cfg_index - REG_CHAN0] <= chan_load(cfg_data[9:0]);
				end
			endcase
		end
	end

	// Generator state
	phase_t      phase_q, phase_d;
	logic [2:0]  slot_q, slot_d;
	logic [15:0] count_q, count_d;
	logic [23:0] frame_q, frame_d;
	logic        fstart_d, ovr_d;

	logic        accept;
	logic        tick;
	logic        expiry;
	logic [24:0] frame_inc;
	logic [15:0] next_chan_load;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign tick      = s_axis_tdata[0];
	assign frame_inc = {1'b0, frame_q} + 25'd1;
	assign expiry    = frame_inc >= {1'b0, period_q};

	always_comb begin
		if (slot_q < 3'(REG_CHANNELS)) begin
			next_chan_load = chan_load_q[slot_q];
		end else begin
			next_chan_load = BASE_TICKS - 16'd1;
		end
	end

	// Next state for one tick
	always_comb begin
		phase_d  = phase_q;
		slot_d   = slot_q;
		count_d  = count_q;
		frame_d  = frame_q;
		fstart_d = 1'b0;
		ovr_d    = 1'b0;
		if (tick) begin
			frame_d = expiry ? 24'd0 : frame_inc[23:0];
			case (phase_q)
				PH_SEP, PH_CHAN: begin
					ovr_d = expiry;
					if (count_q != 16'd0) begin
						count_d = count_q - 16'd1;
					end else if (phase_q == PH_SEP) begin
						if (slot_q < 3'(CHAN_COUNT)) begin
							phase_d = PH_CHAN;
							count_d = next_chan_load;
						end else begin
							phase_d = PH_IDLE;
							slot_d  = 3'd0;
							count_d = 16'd0;
						end
					end else begin
						slot_d  = slot_q + 3'd1;
						phase_d = PH_SEP;
						count_d = sep_load_q;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					if (expiry) begin
						slot_d   = 3'd0;
						phase_d  = PH_SEP;
						count_d  = sep_load_q;
						fstart_d = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			slot_q  <= 3'd0;
			count_q <= 16'd0;
			frame_q <= 24'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			slot_q  <= slot_d;
			count_q <= count_d;
			frame_q <= frame_d;
		end
	end

	// Result register
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic [2:0] slot_out;
	logic       level_out;

	assign level_out = (phase_d != PH_SEP);
	assign slot_out  = (phase_d == PH_SEP || phase_d == PH_CHAN) ? slot_d : SLOT_IDLE;

	assign s_axis_tready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {2'b00, ovr_d, fstart_d, slot_out, level_out};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

/* hw/rtl/rcppm_checker.sv */
`default_nettype none
module rcppm_checker
	import rcppm_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [7:0]  m_axis_tdata
);

	// Empty result register never blocks a tick request
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("tick request blocked with empty result register");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// A train begins with the first separator of slot zero
	a_fstart_sep: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[OUT_FSTART_BIT] |->
			!m_axis_tdata[OUT_LEVEL_BIT] && m_axis_tdata[OUT_SLOT_LSB+2:OUT_SLOT_LSB] == 3'd0
			&& !m_axis_tdata[OUT_OVR_BIT])
		else $error("frame start without a slot zero separator");

	// Idle line is high
	a_idle_high: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[OUT_SLOT_LSB+2:OUT_SLOT_LSB] == SLOT_IDLE |->
			m_axis_tdata[OUT_LEVEL_BIT])
		else $error("idle slot with low line");

endmodule

bind rc_ppm_frame_generator rcppm_checker u_rcppm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

/* bench/rc_ppm_frame_generator_tb.sv */
`timescale 1ns / 100ps
module rc_ppm_frame_generator_tb;
	import rcppm_pkg::*;

	localparam int CHAN_COUNT     = 6;
	localparam int VALUE_BITS     = 10;
	localparam int WATCHDOG_LIMIT = 2000;

	// Idle modes for either side of the stream
	localparam int IDLE_NONE   = 0;
	localparam int IDLE_FULL   = 1;
	localparam int IDLE_SPARSE = 2;

	// One predicted output sample of the PPM line
	typedef struct {
		logic       level;
		logic [2:0] slot;
		logic       fstart;
		logic       ovr;
	} ppm_sample_t;

	// Tracks the encoder state and holds the line samples still owed by the block
	class ppm_line_board;
		logic [23:0] period;
		logic [15:0] sep_ticks;
		logic [9:0]  chan [REG_CHANNELS];
		phase_t      ph;
		logic [2:0]  slot;
		logic [15:0] cnt;
		logic [23:0] fcount;
		logic        lvl;
		ppm_sample_t pending [$];
		int          errors;
		int          ticks_seen;
		int          frame_starts;
		int          overruns;
		int          trains_done;

		function new();
			period    = PERIOD_RESET;
			sep_ticks = SEP_RESET;
			foreach (chan[i])
				chan[i] = CHAN_RESET[i];
			ph     = PH_IDLE;
			slot   = '0;
			cnt    = '0;
			fcount = '0;
			lvl    = 1'b1;
		endfunction

		function void write_reg(logic [2:0] idx, logic [23:0] data);
			if (idx == REG_FRAME_PERIOD) begin
				period = data;
			end else if (idx == REG_SEP_LOW) begin
				sep_ticks = data[15:0];
			end else if (idx >= REG_CHAN0 && idx < REG_CHAN0 + REG_CHANNELS) begin
				chan[idx - REG_CHAN0] = data[9:0];
			end
		endfunction

		function void start_separator();
			ph  = PH_SEP;
			lvl = 1'b0;
			cnt = (sep_ticks == 0) ? 16'd0 : sep_ticks - 16'd1;
		endfunction

		// High interval: base plus scaled channel position, counted down to zero
		function void start_channel();
			int unsigned v;
			int unsigned dur;
			v   = (slot < REG_CHANNELS) ? chan[slot] : 0;
			dur = BASE_TICKS + ((v * SPAN_TICKS) >> VALUE_BITS);
			ph  = PH_CHAN;
			lvl = 1'b1;
			cnt = 16'(dur - 1);
		endfunction

		// Advance by one accepted request and queue the line sample it yields
		function void take_tick(bit t);
			ppm_sample_t s;
			bit          expiry;
			s = '{level: 1'b0, slot: 3'd0, fstart: 1'b0, ovr: 1'b0};
			if (ph != PH_SEP && ph != PH_CHAN) begin
				ph  = PH_IDLE;
				lvl = 1'b1;
			end
			if (t) begin
				ticks_seen++;
				expiry = ({1'b0, fcount} + 25'd1) >= {1'b0, period};
				fcount = expiry ? 24'd0 : fcount + 24'd1;
				if (ph == PH_IDLE) begin
					if (expiry) begin
						slot = '0;
						start_separator();
						s.fstart = 1'b1;
						frame_starts++;
					end
				end else begin
					if (expiry) begin
						s.ovr = 1'b1;
						overruns++;
					end
					if (cnt != 0) begin
						cnt--;
					end else if (ph == PH_SEP) begin
						if (slot < CHAN_COUNT) begin
							start_channel();
						end else begin
							// final separator done: back to idle high
							ph   = PH_IDLE;
							lvl  = 1'b1;
							slot = '0;
							cnt  = '0;
							trains_done++;
						end
					end else begin
						slot = slot + 3'd1;
						start_separator();
					end
				end
			end
			s.level = lvl;
			s.slot  = (ph == PH_IDLE) ? SLOT_IDLE : slot;
			pending.push_back(s);
		endfunction

		function void check_item(logic [7:0] d);
			ppm_sample_t e;
			if (pending.size() == 0) begin
				$error("result with no request outstanding, tdata %h", d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[OUT_LEVEL_BIT] !== e.level) begin
				$error("ppm_level: expected %0d, got %0d", e.level, d[OUT_LEVEL_BIT]);
				errors++;
			end
			if (d[OUT_SLOT_LSB +: 3] !== e.slot) begin
				$error("active_slot: expected %0d, got %0d", e.slot, d[OUT_SLOT_LSB +: 3]);
				errors++;
			end
			if (d[OUT_FSTART_BIT] !== e.fstart) begin
				$error("frame_start: expected %0d, got %0d", e.fstart, d[OUT_FSTART_BIT]);
				errors++;
			end
			if (d[OUT_OVR_BIT] !== e.ovr) begin
				$error("overrun: expected %0d, got %0d", e.ovr, d[OUT_OVR_BIT]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [0] tick, [7:1] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // [0] ppm_level, [3:1] active_slot, [4] frame_start,
	                             // [5] overrun, [7:6] zero
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	ppm_line_board board;
	int            src_idle;
	int            snk_idle;
	int            idle_cycles;

	rc_ppm_frame_generator #(
		.CHAN_COUNT (CHAN_COUNT),
		.VALUE_BITS (VALUE_BITS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int draw_gap(int mode);
		if (mode == IDLE_FULL)
			return $urandom_range(0, 13);
		if (mode == IDLE_SPARSE)
			return ($urandom_range(0, 15) == 0) ? $urandom_range(1, 13) : 0;
		return 0;
	endfunction

	// Present one tick request; called and returns at a falling edge
	task automatic push_tick(bit t, int gap);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {7'd0, t};
		@(posedge clk);
		while (s_axis_tready !== 1'b1)
			@(posedge clk);
		board.take_tick(t);
		@(negedge clk);
	endtask

	task automatic run_ticks(int n, int one_pct);
		bit t;
		for (int i = 0; i < n; i++) begin
			t = ($urandom_range(0, 99) < one_pct);
			push_tick(t, draw_gap(src_idle));
		end
	endtask

	// Stop requesting and wait for every owed sample
	task automatic settle();
		s_axis_tvalid = 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [23:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Result side: random stall before each sample, then take it
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = draw_gap(snk_idle);
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			@(posedge clk);
			while (m_axis_tvalid !== 1'b1)
				@(posedge clk);
			board.check_item(m_axis_tdata);
			@(negedge clk);
		end
	end

	// Watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("rc_ppm_frame_generator_tb failed");
			$finish;
		end
	end

	initial begin
		int unsigned v;
		logic [2:0]  idx;
		logic [23:0] data;
		int          pick;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		src_idle      = IDLE_NONE;
		snk_idle      = IDLE_NONE;
		idle_cycles   = 0;
		board         = new();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: holds and ticks at reset settings
		push_tick(1'b0, 0);
		push_tick(1'b1, 0);
		push_tick(1'b1, 0);
		push_tick(1'b0, 0);
		settle();

		// Zero period and zero separator: train starts on the first tick, every later tick overruns
		set_reg(REG_FRAME_PERIOD, 24'd0);
		set_reg(REG_SEP_LOW, 24'hFF0000);
		push_tick(1'b1, 0);
		push_tick(1'b0, 0);
		push_tick(1'b1, 0);
		push_tick(1'b1, 0);
		push_tick(1'b0, 3);
		push_tick(1'b1, 0);
		settle();

		// Widest separator and period of one, changed mid-interval
		set_reg(REG_SEP_LOW, 24'h00FFFF);
		set_reg(REG_FRAME_PERIOD, 24'd1);
		set_reg(REG_CHAN0 + 3'd1, 24'hFFFFFF);
		snk_idle = IDLE_FULL;
		push_tick(1'b1, 2);
		push_tick(1'b1, 0);
		push_tick(1'b0, 5);
		push_tick(1'b1, 13);
		push_tick(1'b1, 0);
		settle();

		// Short runs over a spread of widths and frame periods
		for (int k = 0; k < 16; k++) begin
			settle();
			case (k % 4)
				0: data = 24'($urandom_range(0, 3));
				1: data = 24'($urandom_range(4, 5000));
				2: data = 24'($urandom_range(100000, 200000));
				default: data = (k == 3) ? 24'hFFFFFF : 24'($urandom);
			endcase
			set_reg(REG_FRAME_PERIOD, data);
			v = (k == 5 || k == 6) ? 16'hFFFF : $urandom_range(0, 40);
			set_reg(REG_SEP_LOW, {8'($urandom), 16'(v)});
			for (int c = 0; c < REG_CHANNELS; c++) begin
				pick = $urandom_range(0, 7);
				v = (pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(0, 63);
				set_reg(REG_CHAN0 + 3'(c), {14'($urandom), 10'(v)});
			end
			src_idle = (k % 2 == 0) ? IDLE_NONE : IDLE_SPARSE;
			snk_idle = (k % 3 == 0) ? IDLE_SPARSE : IDLE_NONE;
			run_ticks(40, 97);
		end

		// Random settings, heavy idling on both sides
		for (int k = 0; k < 14; k++) begin
			settle();
			repeat ($urandom_range(1, 3)) begin
				idx  = 3'($urandom_range(0, 7));
				pick = $urandom_range(0, 3);
				data = (pick == 0) ? 24'h0 : (pick == 1) ? 24'hFFFFFF : 24'($urandom);
				set_reg(idx, data);
			end
			src_idle = (k % 5 == 4) ? IDLE_NONE : IDLE_FULL;
			snk_idle = (k % 4 == 3) ? IDLE_NONE : IDLE_FULL;
			run_ticks(55, 75);
		end

		// Drain and let the pipeline settle
		s_axis_tvalid = 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("covered %0d timer ticks: %0d frame starts, %0d overruns, %0d trains finished",
			board.ticks_seen, board.frame_starts, board.overruns, board.trains_done);
		$display("mismatches found: %0d", board.errors);
		if (board.errors == 0)
			$display("rc_ppm_frame_generator_tb passed");
		else
			$display("rc_ppm_frame_generator_tb failed");
		$finish;
	end

endmodule
